// File: rtl/fpt_pkg.sv
// Shared types and constants for the four-plane tile pixel generator.
// No dependencies; used by every module of the block.
`default_nettype none

package fpt_pkg;

  localparam int unsigned PAGE_AW    = 12;
  localparam int unsigned PAGE_DEPTH = 1 << PAGE_AW;
  localparam int unsigned NUM_PAGES  = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PEN_W      = 10;
  localparam int unsigned OFS_W      = 9;
  localparam int unsigned PAL_W      = 2;

  // Page numbers.
  localparam logic [1:0] PAGE_B = 2'd0;

  // Scroll memory selects (address bits 10..8) for planes D and F.
  localparam logic [2:0] SCROLL_SEL_D = 3'd4;
  localparam logic [2:0] SCROLL_SEL_F = 3'd6;

  typedef enum logic [1:0] {
    OP_BYTE_WR   = 2'd0,
    OP_SCROLL_WR = 2'd1,
    OP_PIXEL     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_PALETTE = 2'd0,
    CFG_VOFS    = 2'd1,
    CFG_HOFS    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CODE,
    ST_GLYPH
  } state_t;

  // Result of one pixel lookup, before the output register.
  typedef struct packed {
    logic             visible;
    logic [PEN_W-1:0] pen;
    logic [7:0]       sx;
    logic [7:0]       sy;
  } pix_result_t;

endpackage

`default_nettype wire

// File: rtl/four_plane_tile_pixel_generator.sv
// Four-plane tile pixel generator: top level with sequencer, page RAMs,
// scroll and mirror registers, and output register. Depends on fpt_pkg,
// fpt_page_ram and fpt_pen_pack.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: a page byte
//   write, a scroll memory write or a pixel lookup. Result channel
//   (out_valid / out_stall) returns one pen and screen position for each
//   pixel request that lands on screen; writes and off-screen pixels give
//   nothing. Configuration channel (cfg_valid / cfg_ready) sets palette and
//   mirror offsets; it is always ready and should be written while idle.
// Pixel sequence:
//   A pixel request reads the tile code of every page when it is accepted
//   and the glyph line in the code state, so the page RAM read port sets
//   the rate; the pen is registered at the end of the glyph state. The
//   next request is taken in the glyph cycle, while this pixel finishes.
// Reset:
//   rst_n (synchronous, active low) starts a clearing pass that zeroes all
//   four pages in parallel, one address per cycle, with in_stall high
//   throughout. Configuration writes are taken during the pass.
// Back-pressure:
//   A result waiting under out_stall holds; the next pixel is held in its
//   glyph cycle until the output register frees, while the register itself
//   lets a new request be taken as soon as the old result leaves.
`default_nettype none

module four_plane_tile_pixel_generator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_op,
  input  wire logic [1:0]                  in_plane,
  input  wire logic [11:0]                 in_address,
  input  wire logic [7:0]                  in_wr_data,
  input  wire logic [7:0]                  in_row,
  input  wire logic [7:0]                  in_column,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [fpt_pkg::PEN_W-1:0]        out_pen_index,
  output logic [7:0]                       out_screen_x,
  output logic [7:0]                       out_screen_y,
  // configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [fpt_pkg::OFS_W-1:0]   cfg_wdata
);
  import fpt_pkg::*;

  state_t state_r, state_nxt;

  logic [PAGE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic               in_ready;
  logic               accept;
  logic               accept_pixel;
  logic               slot_free;
  logic               ram_re;
  logic               clear_done;

  // Configuration and scroll registers.
  logic [PAL_W-1:0]   palette_r;
  logic [OFS_W-1:0]   vofs_r;
  logic [OFS_W-1:0]   hofs_r;
  logic [2:0][7:0]    scroll_r;
  logic [2:0]         scroll_sel;
  // Scroll per page; page B is never scrolled.
  logic [NUM_PAGES-1:0][7:0] page_scroll;

  // Request held through the lookup.
  logic [7:0]         row_r;
  logic [7:0]         col_r;
  logic [3:0]         color_r;

  // Page RAM ports.
  logic [NUM_PAGES-1:0]              ram_we;
  logic [PAGE_AW-1:0]                ram_waddr;
  logic [BYTE_W-1:0]                 ram_wdata;
  logic [NUM_PAGES-1:0][PAGE_AW-1:0] ram_raddr;
  logic [NUM_PAGES-1:0][BYTE_W-1:0]  ram_rdata;

  pix_result_t        pix;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [PEN_W-1:0]   out_pen_r;
  logic [7:0]         out_sx_r;
  logic [7:0]         out_sy_r;
  logic               out_load;

  assign cfg_ready    = 1'b1;
  assign slot_free    = !out_valid_r || !out_stall;
  assign clear_done   = &clr_cnt_r;
  assign accept       = in_valid && in_ready;
  assign accept_pixel = accept && (in_op == OP_PIXEL);
  assign scroll_sel   = in_address[10:8];
  assign page_scroll  = {scroll_r, 8'h00};

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept_pixel) state_nxt = ST_CODE;
      end
      ST_CODE: begin
        state_nxt = ST_GLYPH;
      end
      ST_GLYPH: begin
        // Once the output slot is free, finish this pixel and, if one comes in, start the next.
        if (slot_free) state_nxt = accept_pixel ? ST_CODE : ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    ram_re   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        in_ready = 1'b0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_re   = accept_pixel;
      end
      ST_CODE: begin
        // Issue the glyph line reads.
        ram_re = 1'b1;
      end
      ST_GLYPH: begin
        in_ready = slot_free;
        out_load = slot_free && pix.visible;
        ram_re   = accept_pixel;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Advance the clear address only during the pass.
  assign clr_cnt_nxt = (state_r == ST_CLEAR) ? clr_cnt_r + 1'b1 : clr_cnt_r;

  // ---------------------------------------------------------------------
  // Page RAM write side: clearing pass or byte write request
  // ---------------------------------------------------------------------
  always_comb begin
    ram_we    = '0;
    ram_waddr = in_address;
    ram_wdata = in_wr_data;
    if (state_r == ST_CLEAR) begin
      ram_we    = '1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (accept && (in_op == OP_BYTE_WR)) begin
      ram_we[in_plane] = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Page RAM read side. On accept: tile code at the (scrolled) tile.
  // In the code cycle: glyph line at 0x800 + code * 8 + line.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [7:0] scr;
    logic [7:0] ey;
    for (int p = 0; p < NUM_PAGES; p++) begin
      scr = page_scroll[p];
      if (state_r == ST_CODE) begin
        ey           = row_r - scr;
        ram_raddr[p] = {1'b1, ram_rdata[p], ey[2:0]};
      end else begin
        ey           = in_row - scr;
        ram_raddr[p] = {2'b00, ey[7:3], in_column[7:3]};
      end
    end
  end

  for (genvar p = 0; p < NUM_PAGES; p++) begin : g_page
    fpt_page_ram #(
      .ADDR_W (PAGE_AW),
      .DATA_W (BYTE_W)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[p]),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr[p]),
      .rdata (ram_rdata[p])
    );
  end

  // Hold the pixel position; capture the page-B color nibble from the code.
  always_ff @(posedge clk) begin
    if (accept_pixel) begin
      row_r <= in_row;
      col_r <= in_column;
    end
    if (state_r == ST_CODE) begin
      color_r <= ram_rdata[PAGE_B][7:4];
    end
  end

  // ---------------------------------------------------------------------
  // Scroll memory: only selects D..F with data bit 0 set take effect.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r <= '0;
    end else if (accept && (in_op == OP_SCROLL_WR) && in_wr_data[0]
                 && (scroll_sel inside {[SCROLL_SEL_D:SCROLL_SEL_F]})) begin
      scroll_r[scroll_sel[1:0]] <= in_address[7:0];
    end
  end

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r <= '0;
      vofs_r    <= '0;
      hofs_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PALETTE: palette_r <= cfg_wdata[PAL_W-1:0];
        CFG_VOFS:    vofs_r    <= cfg_wdata;
        CFG_HOFS:    hofs_r    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pen packing and placement
  // ---------------------------------------------------------------------
  fpt_pen_pack u_pen_pack (
    .glyph   (ram_rdata),
    .color   (color_r),
    .row     (row_r),
    .column  (col_r),
    .palette (palette_r),
    .vofs    (vofs_r),
    .hofs    (hofs_r),
    .result  (pix)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pen_r <= pix.pen;
      out_sx_r  <= pix.sx;
      out_sy_r  <= pix.sy;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pen_index = out_pen_r;
  assign out_screen_x  = out_sx_r;
  assign out_screen_y  = out_sy_r;

`ifndef ASSERT_OFF
  // No request is taken while the pages are being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("request accepted during clearing pass");

  // The code cycle is always followed by the glyph cycle.
  a_code_to_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CODE) |=> (state_r == ST_GLYPH))
    else $error("glyph cycle did not follow code cycle");

  // A new result appears only after a glyph cycle.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_GLYPH))
    else $error("result loaded outside glyph cycle");

  // Writes and reads never share a cycle on the page RAMs.
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (ram_we == '0))
    else $error("page RAM read and write in the same cycle");
`endif

endmodule

`default_nettype wire

// File: rtl/fpt_page_ram.sv
// One tile page: synchronous single-write, single-read RAM, registered read.
// Depends on fpt_pkg for default sizes.
`default_nettype none

module fpt_page_ram #(
  parameter int unsigned ADDR_W = fpt_pkg::PAGE_AW,
  parameter int unsigned DATA_W = fpt_pkg::BYTE_W
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/fpt_pen_pack.sv
// Pen packing and screen placement for one pixel from the four glyph bytes.
// Depends on fpt_pkg for widths and the result struct.
`default_nettype none

module fpt_pen_pack (
  input  wire logic [fpt_pkg::NUM_PAGES-1:0][7:0] glyph,
  input  wire logic [3:0]                          color,
  input  wire logic [7:0]                          row,
  input  wire logic [7:0]                          column,
  input  wire logic [fpt_pkg::PAL_W-1:0]           palette,
  input  wire logic [fpt_pkg::OFS_W-1:0]           vofs,
  input  wire logic [fpt_pkg::OFS_W-1:0]           hofs,
  output fpt_pkg::pix_result_t                     result
);
  import fpt_pkg::*;

  logic [NUM_PAGES-1:0] bits;
  logic [2:0]           bit_sel;
  logic [10:0]          sy;
  logic [10:0]          sx;

  // Leftmost column takes the glyph's most significant bit.
  assign bit_sel = ~column[2:0];

  always_comb begin
    for (int p = 0; p < NUM_PAGES; p++) begin
      bits[p] = glyph[p][bit_sel];
    end
  end

  assign sy = {3'b000, row} + {{2{vofs[OFS_W-1]}}, vofs};
  assign sx = {3'b000, column} - {{2{hofs[OFS_W-1]}}, hofs};

  always_comb begin
    result.visible = (sy[10:8] == 3'b000) && (sx[10:8] == 3'b000);
    // palette, D, E, F, B, color nibble
    result.pen     = {palette, bits[1], bits[2], bits[3], bits[0], color};
    result.sx      = sx[7:0];
    result.sy      = sy[7:0];
  end

endmodule

`default_nettype wire

// File: tb/tb_four_plane_tile_pixel_generator.sv
`timescale 1ns / 100ps
// Self-checking testbench for four_plane_tile_pixel_generator: a directed table,
// then random requests under several palette and mirror settings.
// Depends on fpt_pkg and the RTL of the block; reads no files.

module tb_four_plane_tile_pixel_generator;
  import fpt_pkg::*;

  // Pages D, E, F and the scroll select of plane E (B and D/F come from the package).
  localparam logic [1:0] PG_D       = 2'd1;
  localparam logic [1:0] PG_E       = 2'd2;
  localparam logic [1:0] PG_F       = 2'd3;
  localparam logic [2:0] SEL_E      = 3'd5;
  // Op code that the block does not decode.
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam int RANDOM_ITEMS = 1950;
  localparam int PHASES       = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AT      = 700;   // request count that starts the long hold-off
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [PEN_W-1:0] pen;
    logic [7:0]       sx;
    logic [7:0]       sy;
  } pixel_t;

  // How a directed row is checked: by the predictor, against a typed-in
  // result, or as a pixel that must not show up.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_GIVEN,
    CHK_NONE
  } check_t;

  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_PERIODIC
  } sink_mode_t;

  typedef struct {
    bit         is_cfg;
    cfg_reg_t   reg_idx;
    logic [8:0] reg_val;
    logic [1:0] op;
    logic [1:0] plane;
    logic [11:0] addr;
    logic [7:0] data;
    logic [7:0] row;
    logic [7:0] col;
    check_t     chk;
    pixel_t     want;
  } dir_row_t;

  typedef struct {
    logic [1:0] pal;
    logic [8:0] vofs;
    logic [8:0] hofs;
  } reg_set_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_op;
  logic [1:0]        in_plane;
  logic [11:0]       in_address;
  logic [7:0]        in_wr_data;
  logic [7:0]        in_row;
  logic [7:0]        in_column;
  logic              out_valid;
  logic              out_stall;
  logic [PEN_W-1:0]  out_pen_index;
  logic [7:0]        out_screen_x;
  logic [7:0]        out_screen_y;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [OFS_W-1:0]  cfg_wdata;

  // Predictor state: the four pages back to back, the D/E/F scroll rows,
  // and the three registers.
  logic [7:0]        page_bytes [0:4*PAGE_DEPTH-1];
  logic [7:0]        scroll_rows [0:2];
  logic [1:0]        pal_bits;
  logic signed [8:0] row_shift;
  logic signed [8:0] col_shift;

  pixel_t            pending_pixels [$];
  dir_row_t          directed_requests [$];
  reg_set_t          phase_settings [PHASES];
  logic [7:0]        code_pool [6];

  int                mismatch_count = 0;
  int                accepted_requests = 0;
  int                burst_left = 0;

  four_plane_tile_pixel_generator i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_plane      (in_plane),
    .in_address    (in_address),
    .in_wr_data    (in_wr_data),
    .in_row        (in_row),
    .in_column     (in_column),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pen_index (out_pen_index),
    .out_screen_x  (out_screen_x),
    .out_screen_y  (out_screen_y),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run (clear pass, every pixel
  // under the heaviest stall, every sender gap).
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // One plane's bit: scroll the row, fetch the tile code, then the glyph line,
  // leftmost column from the glyph's top bit.
  function automatic logic plane_bit(input logic [1:0] page, input logic [7:0] r, c, scr);
    logic [7:0] ey;
    logic [7:0] code;
    logic [7:0] glyph;
    ey    = r - scr;
    code  = page_bytes[{page, 2'b00, ey[7:3], c[7:3]}];
    glyph = page_bytes[{page, 1'b1, code, ey[2:0]}];
    return glyph[~c[2:0]];
  endfunction

  // Apply one accepted request to the predictor; queue the pixel it yields, if any.
  function automatic void apply_request(input logic [1:0] op, plane, input logic [11:0] addr,
                                        input logic [7:0] data, row, col);
    pixel_t res;
    int     sx;
    int     sy;
    case (op)
      OP_BYTE_WR: page_bytes[{plane, addr}] = data;
      OP_SCROLL_WR: begin
        // only selects D..F with the enable bit set take effect; bit 11 is ignored
        if (data[0] && addr[10:8] >= SCROLL_SEL_D && addr[10:8] <= SCROLL_SEL_F)
          scroll_rows[addr[10:8] - SCROLL_SEL_D] = addr[7:0];
      end
      OP_PIXEL: begin
        sy = int'(row) + int'(row_shift);
        sx = int'(col) - int'(col_shift);
        res.pen = {pal_bits,
                   plane_bit(PG_D, row, col, scroll_rows[0]),
                   plane_bit(PG_E, row, col, scroll_rows[1]),
                   plane_bit(PG_F, row, col, scroll_rows[2]),
                   plane_bit(PAGE_B, row, col, 8'h00),
                   page_bytes[{PAGE_B, 2'b00, row[7:3], col[7:3]}][7:4]};
        res.sx = sx[7:0];
        res.sy = sy[7:0];
        // drop pixels that land off the 256x256 screen
        if (sx >= 0 && sx <= 255 && sy >= 0 && sy <= 255)
          pending_pixels.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic dir_row_t dir_req(input logic [1:0] op, plane, input logic [11:0] addr,
                                       input logic [7:0] data, row, col);
    dir_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = CFG_PALETTE;
    r.reg_val = '0;
    r.op      = op;
    r.plane   = plane;
    r.addr    = addr;
    r.data    = data;
    r.row     = row;
    r.col     = col;
    r.chk     = CHK_MODEL;
    r.want    = '0;
    return r;
  endfunction

  function automatic dir_row_t dir_pixel(input logic [7:0] row, col, input check_t chk,
                                         input pixel_t want);
    dir_row_t r;
    r      = dir_req(OP_PIXEL, PAGE_B, 12'h000, 8'h00, row, col);
    r.chk  = chk;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t dir_cfg(input cfg_reg_t idx, input logic [8:0] val);
    dir_row_t r;
    r         = dir_req(OP_PIXEL, PAGE_B, 12'h000, 8'h00, 8'h00, 8'h00);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Offer one request in bursts: between bursts drop valid for a random gap,
  // then hold the payload until the block takes it.
  task automatic send_request(input logic [1:0] op, plane, input logic [11:0] addr,
                              input logic [7:0] data, row, col);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_op      <= op;
    in_plane   <= plane;
    in_address <= addr;
    in_wr_data <= data;
    in_row     <= row;
    in_column  <= col;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    accepted_requests++;
  endtask

  // Stop offering, wait for every queued pixel, then give in-flight writes
  // and off-screen pixels time to leave the pipeline.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [8:0] val);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_PALETTE: pal_bits  = val[1:0];
      CFG_VOFS:    row_shift = val;
      default:     col_shift = val;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: stall on a pattern that changes mode after a random span,
  // and once hold off for a long stretch so the block backs up.
  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned span;
    int unsigned tick;
    bit          held;
    out_stall = 1'b0;
    mode      = SINK_FREE;
    span      = 0;
    tick      = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && accepted_requests >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (span == 0) begin
        mode = sink_mode_t'($urandom_range(3));
        span = $urandom_range(32, 256);
      end
      span--;
      tick++;
      case (mode)
        SINK_FREE:  out_stall <= 1'b0;
        SINK_LIGHT: out_stall <= ($urandom_range(3) == 0);
        SINK_HEAVY: out_stall <= ($urandom_range(3) != 0);
        default:    out_stall <= (tick % 7) < 3;
      endcase
    end
  end

  // Result checker: each accepted result must match the oldest queued pixel.
  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual pen %h x %0d y %0d",
                 $time, out_pen_index, out_screen_x, out_screen_y);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pen_index !== want.pen) begin
          mismatch_count++;
          $display("%0t: pen_index mismatch: expected %h actual %h",
                   $time, want.pen, out_pen_index);
        end
        if (out_screen_x !== want.sx) begin
          mismatch_count++;
          $display("%0t: screen_x mismatch: expected %0d actual %0d",
                   $time, want.sx, out_screen_x);
        end
        if (out_screen_y !== want.sy) begin
          mismatch_count++;
          $display("%0t: screen_y mismatch: expected %0d actual %0d",
                   $time, want.sy, out_screen_y);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t    r;
    int unsigned pick;
    int unsigned sub;
    logic [1:0]  op;
    logic [1:0]  plane;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [4:0]  trow;
    logic [4:0]  tcol;

    // Drive every input to a known value before the first edge.
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_BYTE_WR;
    in_plane   = PAGE_B;
    in_address = '0;
    in_wr_data = '0;
    in_row     = '0;
    in_column  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_PALETTE;
    cfg_wdata  = '0;

    for (int i = 0; i < 4 * PAGE_DEPTH; i++) page_bytes[i] = 8'h00;
    for (int i = 0; i < 3; i++) scroll_rows[i] = 8'h00;
    pal_bits  = '0;
    row_shift = '0;
    col_shift = '0;

    // A few tile codes that random glyph writes aim at, so pixels hit set bits.
    code_pool[0] = 8'h00;
    code_pool[1] = 8'h01;
    code_pool[2] = 8'h5A;
    code_pool[3] = 8'h9C;
    code_pool[4] = 8'hF0;
    code_pool[5] = 8'hFF;

    // Extremes first, then two random settings.
    phase_settings[0] = '{2'd0, 9'h000, 9'h000};
    phase_settings[1] = '{2'd3, 9'h0FF, 9'h101};
    phase_settings[2] = '{2'd1, 9'h101, 9'h0FF};
    phase_settings[3] = '{2'd2, 9'h008, 9'h1F8};
    for (int i = 4; i < PHASES; i++) begin
      phase_settings[i].pal  = 2'($urandom);
      phase_settings[i].vofs = 9'(int'($urandom_range(0, 510)) - 255);
      phase_settings[i].hofs = 9'(int'($urandom_range(0, 510)) - 255);
    end

    // Directed table. A freshly cleared store reads as pen 0 at the source position.
    directed_requests.push_back(dir_pixel(8'd0, 8'd0, CHK_GIVEN, '{10'h000, 8'd0, 8'd0}));
    directed_requests.push_back(dir_pixel(8'd255, 8'd255, CHK_GIVEN,
                                          '{10'h000, 8'd255, 8'd255}));
    // Build a few tiles and glyph lines on every page.
    directed_requests.push_back(dir_req(OP_BYTE_WR, PAGE_B, 12'h000, 8'hF1, 8'h00, 8'h00));
    directed_requests.push_back(dir_req(OP_BYTE_WR, PAGE_B, 12'hF88, 8'h80, 8'hFF, 8'hFF));
    directed_requests.push_back(dir_req(OP_BYTE_WR, PG_D, 12'h3FF, 8'hFF, 8'h00, 8'h00));
    directed_requests.push_back(dir_req(OP_BYTE_WR, PG_D, 12'hFFF, 8'hFF, 8'h00, 8'h00));
    directed_requests.push_back(dir_req(OP_BYTE_WR, PG_E, 12'h000, 8'h00, 8'h00, 8'h00));
    directed_requests.push_back(dir_req(OP_BYTE_WR, PG_E, 12'h801, 8'h01, 8'h00, 8'h00));
    directed_requests.push_back(dir_req(OP_BYTE_WR, PG_F, 12'h800, 8'h7F, 8'h00, 8'h00));
    // Scroll D by 1, E by 255, F by 7 (the last one with address bit 11 set).
    directed_requests.push_back(dir_req(OP_SCROLL_WR, PAGE_B, {1'b0, SCROLL_SEL_D, 8'h01},
                                        8'h01, 8'h00, 8'h00));
    directed_requests.push_back(dir_req(OP_SCROLL_WR, PAGE_B, {1'b0, SEL_E, 8'hFF},
                                        8'hFF, 8'h00, 8'h00));
    directed_requests.push_back(dir_req(OP_SCROLL_WR, PAGE_B, {1'b1, SCROLL_SEL_F, 8'h07},
                                        8'h01, 8'h00, 8'h00));
    // Scroll writes that must change nothing: enable bit clear, select 7, select 0.
    directed_requests.push_back(dir_req(OP_SCROLL_WR, PAGE_B, {1'b0, SCROLL_SEL_D, 8'hAA},
                                        8'hFE, 8'h00, 8'h00));
    directed_requests.push_back(dir_req(OP_SCROLL_WR, PAGE_B, 12'h7FF, 8'hFF, 8'h00, 8'h00));
    directed_requests.push_back(dir_req(OP_SCROLL_WR, PAGE_B, 12'h000, 8'h01, 8'h00, 8'h00));
    // Undecoded op with every field at its maximum.
    directed_requests.push_back(dir_req(OP_UNUSED, PG_F, 12'hFFF, 8'hFF, 8'hFF, 8'hFF));
    // Pixels that land on the bits written above.
    directed_requests.push_back(dir_pixel(8'd0, 8'd0, CHK_MODEL, '0));
    directed_requests.push_back(dir_pixel(8'd0, 8'd255, CHK_MODEL, '0));
    directed_requests.push_back(dir_pixel(8'd0, 8'd7, CHK_MODEL, '0));
    directed_requests.push_back(dir_pixel(8'd7, 8'd1, CHK_MODEL, '0));
    // Push pixels off each screen edge.
    directed_requests.push_back(dir_cfg(CFG_PALETTE, 9'h003));
    directed_requests.push_back(dir_cfg(CFG_VOFS, 9'h001));
    directed_requests.push_back(dir_pixel(8'd255, 8'd0, CHK_NONE, '0));
    directed_requests.push_back(dir_pixel(8'd254, 8'd255, CHK_MODEL, '0));
    directed_requests.push_back(dir_cfg(CFG_VOFS, 9'h101));
    directed_requests.push_back(dir_cfg(CFG_HOFS, 9'h1FF));
    directed_requests.push_back(dir_pixel(8'd255, 8'd255, CHK_NONE, '0));
    directed_requests.push_back(dir_pixel(8'd255, 8'd254, CHK_MODEL, '0));
    directed_requests.push_back(dir_cfg(CFG_HOFS, 9'h0FF));
    directed_requests.push_back(dir_pixel(8'd0, 8'd0, CHK_NONE, '0));
    directed_requests.push_back(dir_pixel(8'd255, 8'd255, CHK_MODEL, '0));

    // Hold reset, then release; the clearing pass shows up as in_stall.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_requests[i]) begin
      r = directed_requests[i];
      if (r.is_cfg) begin
        write_register(r.reg_idx, r.reg_val);
      end else begin
        send_request(r.op, r.plane, r.addr, r.data, r.row, r.col);
        case (r.chk)
          CHK_MODEL: apply_request(r.op, r.plane, r.addr, r.data, r.row, r.col);
          CHK_GIVEN: pending_pixels.push_back(r.want);
          default:   ;
        endcase
      end
    end

    // Random phases: rewrite all three registers, then a batch of requests.
    for (int p = 0; p < PHASES; p++) begin
      write_register(CFG_PALETTE, {7'd0, phase_settings[p].pal});
      write_register(CFG_VOFS, phase_settings[p].vofs);
      write_register(CFG_HOFS, phase_settings[p].hofs);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        pick  = $urandom_range(99);
        op    = OP_PIXEL;
        plane = 2'($urandom);
        addr  = 12'($urandom);
        data  = 8'($urandom);
        row   = 8'($urandom);
        col   = 8'($urandom);
        if (pick < 35) begin
          op  = OP_BYTE_WR;
          sub = $urandom_range(9);
          if (sub < 4) begin
            // tile map write, mostly into the top-left 4x4 tiles, mostly pool codes
            trow = ($urandom_range(9) < 7) ? 5'($urandom_range(3)) : 5'($urandom);
            tcol = ($urandom_range(9) < 7) ? 5'($urandom_range(3)) : 5'($urandom);
            addr = {2'b00, trow, tcol};
            if ($urandom_range(9) < 7) data = code_pool[$urandom_range(5)];
          end else if (sub < 8) begin
            // glyph line of a pool code
            addr = {1'b1, code_pool[$urandom_range(5)], 3'($urandom)};
          end
        end else if (pick < 45) begin
          op = OP_SCROLL_WR;
          if ($urandom_range(9) < 7) begin
            addr = {1'($urandom), 3'($urandom_range(SCROLL_SEL_D, SCROLL_SEL_F)),
                    ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom)};
            data[0] = 1'b1;
          end
        end else if (pick < 95) begin
          if ($urandom_range(9) < 7) begin
            row = 8'($urandom_range(31));
            col = 8'($urandom_range(31));
          end
        end else begin
          op = OP_UNUSED;
        end
        send_request(op, plane, addr, data, row, col);
        apply_request(op, plane, addr, data, row, col);
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
